FILE: hw/rtl/psls_pkg.sv
`timescale 1ns / 1ps

package psls_pkg;

  // number of statistics entries
  localparam int NUM_SOURCES = 16;
  localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  localparam int SRC_W = 4;
  localparam int CNT_W = 32;   // counts, delays, average
  localparam int SUM_W = 48;   // delay sum
  localparam int DIG_W = 4;    // digit width of the update pass

  localparam int CNT_DIGITS = CNT_W / DIG_W;
  localparam int SUM_DIGITS = SUM_W / DIG_W;

  // one step counter serves the digit pass and the divider
  localparam int STEP_W = $clog2(CNT_W);
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t LO_DIGITS  = step_t'(CNT_DIGITS);
  localparam step_t LAST_DIGIT = step_t'(SUM_DIGITS - 1);
  localparam step_t LAST_DIV   = step_t'(CNT_W - 1);

  typedef enum logic [0:0] {
    CMD_MADE  = 1'b0,
    CMD_EATEN = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PASS,
    ST_FIX,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             cmd;
    logic [SRC_W-1:0] source;
    logic [CNT_W-1:0] delay;
  } in_item_t;

  typedef struct packed {
    logic [SRC_W-1:0] source_out;
    logic [CNT_W-1:0] made_count;
    logic [CNT_W-1:0] eaten_count;
    logic [CNT_W-1:0] dly_min;
    logic [CNT_W-1:0] dly_max;
    logic [CNT_W-1:0] dly_avg;
    logic             mismatch;
  } out_item_t;

endpackage

FILE: hw/rtl/per_source_latency_stats.sv
`timescale 1ns / 1ps

// Per-source latency statistics. Each transaction on the input channel is a
// produced event (cmd 0) or a consumed event with its delay (cmd 1, delay in
// units of 1/1024 ms) for one source; each one returns exactly one result
// transaction with that source's made and eaten counts, min, max and
// truncated average delay after the update, plus a flag when made and eaten
// differ. Counts saturate at all ones, the internal 48-bit sum at 2^48-1,
// the average clamps at all ones. A minimum of zero means none yet. Sources
// at or above NUM_SOURCES update nothing and report zeros. The table is
// cleared by reset, no clearing pass. Items are handled one at a time: an
// in-range item goes through load, a 12-digit update pass (4-bit digits
// over the 48-bit sum), fix-up and done, and through the 32-step restoring
// divider for the average between them, unless the average is zero for
// lack of consumed items or clamps; an out-of-range item goes straight to
// done. The input opens again in the next cycle after the result is loaded;
// while a stalled result still holds the output register, the new result
// waits in done and the input stays closed. The output register lets the
// next transaction be accepted while a result still waits.
module per_source_latency_stats (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  psls_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output psls_pkg::out_item_t  out_data_o
);
  import psls_pkg::*;

  state_e state_q, state_d;

  // statistics table, cleared by reset
  logic [CNT_W-1:0] made_tbl_q  [NUM_SOURCES];
  logic [CNT_W-1:0] eaten_tbl_q [NUM_SOURCES];
  logic [CNT_W-1:0] min_tbl_q   [NUM_SOURCES];
  logic [CNT_W-1:0] max_tbl_q   [NUM_SOURCES];
  logic [SUM_W-1:0] sum_tbl_q   [NUM_SOURCES];

  // working shift registers
  logic             cmd_q;
  logic [SRC_W-1:0] src_q;
  logic [CNT_W-1:0] dly_q;
  logic [CNT_W-1:0] made_q, eaten_q, min_q, max_q;
  logic [SUM_W-1:0] sum_q;
  logic             made_c_q, eaten_c_q, sum_c_q;  // digit carries
  logic             lt_q, gt_q, min_nz_q;          // serial compare flags
  logic [CNT_W-1:0] rem_q, quo_q;                  // divider
  step_t            step_q;

  logic             out_valid_q;
  out_item_t        out_q;

  logic             accept, in_range, tbl_we, out_load, lo_phase;
  logic [IDX_W-1:0] idx;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_range = 32'(in_data_i.source) < 32'(NUM_SOURCES);
  assign idx      = IDX_W'(src_q);
  assign lo_phase = step_q < LO_DIGITS;

  // ---- digit pass arithmetic (LSB digit first) ----
  logic [DIG_W-1:0] dd, md, xd;
  logic [DIG_W:0]   made_dig, eaten_dig, sum_dig;
  logic [DIG_W-1:0] dly_add;
  logic             lt_d, gt_d;

  always_comb begin
    dd        = dly_q[DIG_W-1:0];
    md        = min_q[DIG_W-1:0];
    xd        = max_q[DIG_W-1:0];
    dly_add   = (cmd_q && lo_phase) ? dd : '0;
    made_dig  = {1'b0, made_q[DIG_W-1:0]} + {{DIG_W{1'b0}}, made_c_q};
    eaten_dig = {1'b0, eaten_q[DIG_W-1:0]} + {{DIG_W{1'b0}}, eaten_c_q};
    sum_dig   = {1'b0, sum_q[DIG_W-1:0]} + {1'b0, dly_add} + {{DIG_W{1'b0}}, sum_c_q};
    // higher digits override the verdict of lower ones
    lt_d      = (dd < md) || ((dd == md) && lt_q);
    gt_d      = (dd > xd) || ((dd == xd) && gt_q);
  end

  // ---- fix-up: saturation and min/max selection ----
  logic [CNT_W-1:0] made_f, eaten_f, min_f, max_f, hi_ext;
  logic [SUM_W-1:0] sum_f;
  logic             avg_none, avg_clamp;

  always_comb begin
    made_f    = made_c_q  ? '1 : made_q;   // carry out means it wrapped
    eaten_f   = eaten_c_q ? '1 : eaten_q;
    sum_f     = sum_c_q   ? '1 : sum_q;
    min_f     = (cmd_q && (!min_nz_q || lt_q)) ? dly_q : min_q;
    max_f     = (cmd_q && gt_q) ? dly_q : max_q;
    hi_ext    = CNT_W'(sum_f[SUM_W-1:CNT_W]);
    avg_none  = (eaten_f == '0);
    // quotient needs more than 32 bits when the upper part reaches the divisor
    avg_clamp = !avg_none && (hi_ext >= eaten_f);
  end

  // ---- divider step: one quotient bit per cycle ----
  logic [CNT_W:0]   trial;
  logic [CNT_W+1:0] diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[CNT_W-1]};
    diff  = {1'b0, trial} - {2'b00, eaten_q};
    ge    = !diff[CNT_W+1];
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = in_range ? ST_LOAD : ST_DONE;
      ST_LOAD: state_d = ST_PASS;
      ST_PASS: if (step_q == LAST_DIGIT) state_d = ST_FIX;
      ST_FIX:  state_d = (avg_none || avg_clamp) ? ST_DONE : ST_DIV;
      ST_DIV:  if (step_q == LAST_DIV) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- FSM outputs ----
  always_comb begin
    in_stall_o = 1'b1;
    tbl_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_FIX:  tbl_we     = 1'b1;
      ST_DONE: out_load   = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // table write-back after the fix-up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        made_tbl_q[i]  <= '0;
        eaten_tbl_q[i] <= '0;
        min_tbl_q[i]   <= '0;
        max_tbl_q[i]   <= '0;
        sum_tbl_q[i]   <= '0;
      end
    end else if (tbl_we) begin
      made_tbl_q[idx]  <= made_f;
      eaten_tbl_q[idx] <= eaten_f;
      min_tbl_q[idx]   <= min_f;
      max_tbl_q[idx]   <= max_f;
      sum_tbl_q[idx]   <= sum_f;
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_q <= in_data_i.cmd;
          src_q <= in_data_i.source;
          dly_q <= in_data_i.delay;
          if (!in_range) begin
            // unknown source reports all zeros
            made_q  <= '0;
            eaten_q <= '0;
            min_q   <= '0;
            max_q   <= '0;
            quo_q   <= '0;
          end
        end
      end
      ST_LOAD: begin
        made_q    <= made_tbl_q[idx];
        eaten_q   <= eaten_tbl_q[idx];
        min_q     <= min_tbl_q[idx];
        max_q     <= max_tbl_q[idx];
        sum_q     <= sum_tbl_q[idx];
        made_c_q  <= (cmd_q == CMD_MADE);
        eaten_c_q <= (cmd_q == CMD_EATEN);
        sum_c_q   <= 1'b0;
        lt_q      <= 1'b0;
        gt_q      <= 1'b0;
        min_nz_q  <= 1'b0;
        step_q    <= '0;
      end
      ST_PASS: begin
        sum_q   <= {sum_dig[DIG_W-1:0], sum_q[SUM_W-1:DIG_W]};
        sum_c_q <= sum_dig[DIG_W];
        if (lo_phase) begin
          made_q    <= {made_dig[DIG_W-1:0], made_q[CNT_W-1:DIG_W]};
          made_c_q  <= made_dig[DIG_W];
          eaten_q   <= {eaten_dig[DIG_W-1:0], eaten_q[CNT_W-1:DIG_W]};
          eaten_c_q <= eaten_dig[DIG_W];
          // min, max and delay rotate back to their original order
          min_q     <= {md, min_q[CNT_W-1:DIG_W]};
          max_q     <= {xd, max_q[CNT_W-1:DIG_W]};
          dly_q     <= {dd, dly_q[CNT_W-1:DIG_W]};
          lt_q      <= lt_d;
          gt_q      <= gt_d;
          min_nz_q  <= min_nz_q || (md != '0);
        end
        step_q <= step_q + step_t'(1);
      end
      ST_FIX: begin
        made_q  <= made_f;
        eaten_q <= eaten_f;
        min_q   <= min_f;
        max_q   <= max_f;
        rem_q   <= hi_ext;
        step_q  <= '0;
        if (avg_none) begin
          quo_q <= '0;
        end else if (avg_clamp) begin
          quo_q <= '1;
        end else begin
          quo_q <= sum_f[CNT_W-1:0];
        end
      end
      ST_DIV: begin
        rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_q  <= {quo_q[CNT_W-2:0], ge};
        step_q <= step_q + step_t'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.source_out  <= src_q;
      out_q.made_count  <= made_q;
      out_q.eaten_count <= eaten_q;
      out_q.dly_min     <= min_q;
      out_q.dly_max     <= max_q;
      out_q.dly_avg     <= quo_q;
      out_q.mismatch    <= (made_q != eaten_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/psls_checker.sv
`timescale 1ns / 1ps

module psls_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input psls_pkg::out_item_t  out_data_o
);
  import psls_pkg::*;

  // one item at a time: an accepted transaction blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.mismatch == (out_data_o.made_count != out_data_o.eaten_count)))
    else $error("mismatch flag wrong");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.dly_min != '0)) |->
      (out_data_o.dly_min <= out_data_o.dly_max))
    else $error("min above max");

  a_no_eaten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.eaten_count == '0)) |->
      ((out_data_o.dly_avg == '0) && (out_data_o.dly_max == '0)))
    else $error("delay stats without consumed items");

endmodule

bind per_source_latency_stats psls_checker u_psls_checker (.*);

FILE: test/tb_per_source_latency_stats.sv
`timescale 1ns / 1ps

// Self-checking bench for per_source_latency_stats.
module tb_per_source_latency_stats;
  import psls_pkg::*;

  // Pending event plus its pacing: idle cycles before it is offered, and
  // whether the sender must wait until all outstanding results are back.
  typedef struct {
    in_item_t item;
    int       gap;
    bit       drain;
  } pending_event_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      res_stall = 1'b1;
  out_item_t out_data;

  pending_event_t pending_events[$];
  out_item_t      expected_stats[$];

  // Shadow copy of the statistics table
  logic [CNT_W-1:0] made_tab  [NUM_SOURCES];
  logic [CNT_W-1:0] eaten_tab [NUM_SOURCES];
  logic [CNT_W-1:0] min_tab   [NUM_SOURCES];
  logic [CNT_W-1:0] max_tab   [NUM_SOURCES];
  logic [SUM_W-1:0] sum_tab   [NUM_SOURCES];

  int  error_count   = 0;
  int  results_seen  = 0;
  int  idle_left     = 0;
  bit  fresh_item    = 1'b1;
  logic drv_next_valid;
  int  hold_left     = 0;
  bit  long_hold_done = 1'b0;
  out_item_t want;

  localparam logic [SUM_W-1:0] SUM_LIMIT = '1;
  localparam logic [CNT_W-1:0] CNT_LIMIT = '1;

  per_source_latency_stats u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (res_stall),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one event to the shadow table and return the entry it reports.
  function automatic out_item_t update_stats(in_item_t ev);
    out_item_t        r;
    logic [SUM_W:0]   wide;
    logic [SUM_W-1:0] quo;
    int unsigned      s;
    r = '0;
    r.source_out = ev.source;
    if (ev.source >= NUM_SOURCES) return r;  // out of range: zeros, no update
    s = ev.source;
    if (ev.cmd == CMD_MADE) begin
      if (made_tab[s] != CNT_LIMIT) made_tab[s] = made_tab[s] + 1'b1;
    end else begin
      if (eaten_tab[s] != CNT_LIMIT) eaten_tab[s] = eaten_tab[s] + 1'b1;
      // zero min reads as "none yet", so any delay replaces it
      if (min_tab[s] == '0 || ev.delay < min_tab[s]) min_tab[s] = ev.delay;
      if (ev.delay > max_tab[s]) max_tab[s] = ev.delay;
      wide = {1'b0, sum_tab[s]} + {{(SUM_W+1-CNT_W){1'b0}}, ev.delay};
      sum_tab[s] = (wide > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : wide[SUM_W-1:0];
    end
    quo = '0;
    if (eaten_tab[s] != '0)
      quo = sum_tab[s] / {{(SUM_W-CNT_W){1'b0}}, eaten_tab[s]};
    r.made_count  = made_tab[s];
    r.eaten_count = eaten_tab[s];
    r.dly_min     = min_tab[s];
    r.dly_max     = max_tab[s];
    r.dly_avg     = (quo > {{(SUM_W-CNT_W){1'b0}}, CNT_LIMIT}) ? CNT_LIMIT : quo[CNT_W-1:0];
    r.mismatch    = (made_tab[s] != eaten_tab[s]);
    return r;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 15);
    return $urandom_range(30, 80);
  endfunction

  // Delays: realistic small latencies, zero, all ones and full-range values.
  function automatic logic [CNT_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5)  return $urandom;
    return $urandom_range(1, 5000);
  endfunction

  task automatic add_event(input cmd_e c, input int src, input logic [CNT_W-1:0] d,
                           input int gap, input bit drain);
    pending_event_t pe;
    pe.item.cmd    = c;
    pe.item.source = src[SRC_W-1:0];
    pe.item.delay  = d;
    pe.gap         = gap;
    pe.drain       = drain;
    pending_events.push_back(pe);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Driver: offers the head of the pending queue, keeps it steady while
  // stalled, inserts the requested idle cycles and honors drain points.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      idle_left  = 0;
      fresh_item = 1'b1;
    end else begin
      drv_next_valid = in_valid;
      if (in_valid && !in_stall) begin
        // transaction accepted: predict its result now
        expected_stats.push_back(update_stats(in_data));
        void'(pending_events.pop_front());
        drv_next_valid = 1'b0;
      end
      if (!drv_next_valid && pending_events.size() > 0) begin
        if (fresh_item) begin
          idle_left  = pending_events[0].gap;
          fresh_item = 1'b0;
        end
        if (idle_left > 0) begin
          idle_left--;
        end else if (!pending_events[0].drain || expected_stats.size() == 0) begin
          drv_next_valid = 1'b1;
          in_data       <= pending_events[0].item;
          fresh_item     = 1'b1;
        end
      end
      in_valid <= drv_next_valid;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction
  // and drives the output stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall <= 1'b1;
      hold_left = 0;
    end else begin
      if (out_valid && !res_stall) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          $error("result transaction with no prediction pending: source %0d",
                 out_data.source_out);
          error_count++;
        end else begin
          want = expected_stats.pop_front();
          check_field("source_out",  CNT_W'(want.source_out), CNT_W'(out_data.source_out));
          check_field("made_count",  want.made_count,  out_data.made_count);
          check_field("eaten_count", want.eaten_count, out_data.eaten_count);
          check_field("dly_min",     want.dly_min,     out_data.dly_min);
          check_field("dly_max",     want.dly_max,     out_data.dly_max);
          check_field("dly_avg",     want.dly_avg,     out_data.dly_avg);
          check_field("mismatch",    CNT_W'(want.mismatch), CNT_W'(out_data.mismatch));
        end
      end
      // One long hold-off so the block backs up and stalls its input
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        hold_left      = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (results_seen >= 400 && results_seen < 480) begin
        res_stall <= 1'b0;  // free-running stretch
      end else if ($urandom_range(0, 99) < 30) begin
        hold_left = pick_gap();
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int total;
    int src;
    int n;
    int gap;
    int r;
    bit drain;

    for (int i = 0; i < NUM_SOURCES; i++) begin
      made_tab[i]  = '0;
      eaten_tab[i] = '0;
      min_tab[i]   = '0;
      max_tab[i]   = '0;
      sum_tab[i]   = '0;
    end

    // Directed: edge sources, zero delay as min reset, extremes, averages
    add_event(CMD_MADE,  0,  '0,            0, 1'b0);
    add_event(CMD_EATEN, 0,  '0,            0, 1'b0);  // min stays "none"
    add_event(CMD_EATEN, 0,  32'd5,         1, 1'b0);  // first real min
    add_event(CMD_EATEN, 0,  '0,            0, 1'b0);  // zero clears min
    add_event(CMD_EATEN, 0,  32'd9,         0, 1'b0);  // becomes min again
    add_event(CMD_EATEN, 0,  '1,            2, 1'b0);
    add_event(CMD_MADE,  0,  32'hFFFF_0000, 0, 1'b0);  // delay ignored
    add_event(CMD_MADE,  15, '1,            0, 1'b0);  // avg still zero
    add_event(CMD_MADE,  15, '0,            0, 1'b0);
    add_event(CMD_EATEN, 15, '1,            0, 1'b0);
    add_event(CMD_EATEN, 15, '1,            0, 1'b0);  // avg all ones
    add_event(CMD_EATEN, 15, 32'd1,         3, 1'b0);
    add_event(CMD_EATEN, 15, 32'h8000_0000, 0, 1'b0);
    add_event(CMD_EATEN, 7,  32'h1234_5678, 0, 1'b0);  // consume before make
    add_event(CMD_EATEN, 7,  32'hEDCB_A987, 0, 1'b0);
    add_event(CMD_MADE,  7,  '0,            0, 1'b0);
    add_event(CMD_EATEN, 8,  32'hAAAA_AAAA, 0, 1'b0);
    add_event(CMD_EATEN, 8,  32'h5555_5555, 0, 1'b0);
    add_event(CMD_MADE,  1,  '0,            0, 1'b1);  // after a full drain

    // Random: mostly produce-then-consume bursts per source, some noise
    total = pending_events.size();
    while (total < 700) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        src = $urandom_range(0, NUM_SOURCES - 1);
        n   = $urandom_range(1, 4);
        for (int k = 0; k < 2 * n; k++) begin
          gap   = (total >= 200 && total < 280) ? 0 : pick_gap();
          drain = (total == 350 || total == 550);
          add_event((k < n) ? CMD_MADE : CMD_EATEN, src, pick_delay(), gap, drain);
          total++;
        end
      end else begin
        gap   = (total >= 200 && total < 280) ? 0 : pick_gap();
        drain = (total == 350 || total == 550);
        add_event(cmd_e'($urandom_range(0, 1)), $urandom_range(0, NUM_SOURCES - 1),
                  $urandom, gap, drain);
        total++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_events.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);  // catch any stray result

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #6ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/psls_pkg.sv
hw/rtl/per_source_latency_stats.sv
hw/rtl/psls_checker.sv
test/tb_per_source_latency_stats.sv
